// ===== rtl/free_extent_stack_release_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the free extent stack release block
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef FREE_EXTENT_STACK_RELEASE_DEFINES_SVH
`define FREE_EXTENT_STACK_RELEASE_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge
`define FESR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FESR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/fesr_pkg.sv =====
// ----------------------------------------------------------------------------
// fesr_pkg
// Types and constants of the free extent stack release block.
// ----------------------------------------------------------------------------
`default_nettype none
package fesr_pkg;

   localparam int IN_W    = 48;   // request field width
   localparam int START_W = 49;   // stored start width
   localparam int LEN_W   = 49;   // stored length width
   localparam int SIZE_W  = 51;   // working run length, grows by two merges
   localparam int SUM_W   = 52;   // start plus working length

   localparam logic [START_W-1:0] END_MARK = {START_W{1'b1}};

   // response status codes
   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_BAD_COUNT  = 2'd1;
   localparam logic [1:0] ST_BAD_START  = 2'd2;
   localparam logic [1:0] ST_FULL_DROP  = 2'd3;

   // one stack slot
   typedef struct packed {
      logic [START_W-1:0] start;
      logic [LEN_W-1:0]   len;
   } entry_type;

endpackage
`default_nettype wire

// ===== rtl/fesr_cell.sv =====
// ----------------------------------------------------------------------------
// fesr_cell
// One stack slot of the rotating ring; loads its neighbor when shifting.
// ----------------------------------------------------------------------------
`default_nettype none
module fesr_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               shift_en,
   input  fesr_pkg::entry_type     d_in,
   output fesr_pkg::entry_type     q
);

   fesr_pkg::entry_type slot_ff;

   // reset fills the slot with the end marker
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.start <= fesr_pkg::END_MARK;
         slot_ff.len   <= '0;
      end else if (shift_en) begin
         slot_ff <= d_in;
      end
   end

   assign q = slot_ff;

endmodule
`default_nettype wire

// ===== rtl/fesr_ctrl.sv =====
// ----------------------------------------------------------------------------
// fesr_ctrl
// Sequencer and compare unit at the head of the ring: two scans, one write.
// ----------------------------------------------------------------------------
`default_nettype none
module fesr_ctrl #(
   parameter int STACK_DEPTH = 32
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic [fesr_pkg::IN_W-1:0]  req_start_block,
   input  wire logic [fesr_pkg::IN_W-1:0]  req_block_count,
   output logic                            rsp_strobe,
   output logic [1:0]                      rsp_status,
   input  fesr_pkg::entry_type             head,
   output fesr_pkg::entry_type             wrap,
   output logic                            shift_en
);

   localparam int IDX_W = $clog2(STACK_DEPTH);
   localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(STACK_DEPTH - 1);

   typedef enum logic [1:0] {IDLE, SCAN1, SCAN2, WRITE} state_type;

   state_type                      state_ff, state_in;
   logic [IDX_W-1:0]               idx_ff, idx_in;
   logic [fesr_pkg::START_W-1:0]   bloc_ff, bloc_in;
   logic [fesr_pkg::SIZE_W-1:0]    size_ff, size_in;
   logic [IDX_W-1:0]               target_ff, target_in;
   logic [IDX_W-1:0]               empty_ff, empty_in;
   logic                           found_ff, found_in;
   logic                           have_empty_ff, have_empty_in;
   logic                           chk_below_ff, chk_below_in;
   logic                           full_ff, full_in;
   logic                           done_ff, done_in;
   logic                           rsp_strobe_ff, rsp_strobe_in;
   logic [1:0]                     rsp_status_ff, rsp_status_in;

   logic [fesr_pkg::SUM_W-1:0]     run_end;
   logic [fesr_pkg::START_W:0]     head_end;
   logic                           is_mark, touch_above, touch_below;

   // adjacency compares against the slot at the head of the ring
   assign run_end     = fesr_pkg::SUM_W'(bloc_ff) + fesr_pkg::SUM_W'(size_ff);
   assign head_end    = (fesr_pkg::START_W+1)'(head.start) + (fesr_pkg::START_W+1)'(head.len);
   assign is_mark     = (head.start == fesr_pkg::END_MARK);
   assign touch_above = (fesr_pkg::SUM_W'(head.start) == run_end);
   assign touch_below = ((fesr_pkg::START_W+1)'(bloc_ff) == head_end);

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      bloc_in       = bloc_ff;
      size_in       = size_ff;
      target_in     = target_ff;
      empty_in      = empty_ff;
      found_in      = found_ff;
      have_empty_in = have_empty_ff;
      chk_below_in  = chk_below_ff;
      full_in       = full_ff;
      done_in       = done_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      wrap          = head;
      shift_en      = 1'b0;

      case (state_ff)
         IDLE: begin
            if (start) begin
               bloc_in       = fesr_pkg::START_W'(req_start_block);
               size_in       = fesr_pkg::SIZE_W'(req_block_count);
               idx_in        = TOP_IDX;
               target_in     = '0;
               empty_in      = '0;
               found_in      = 1'b0;
               have_empty_in = 1'b0;
               chk_below_in  = 1'b0;
               full_in       = 1'b0;
               done_in       = 1'b0;
               if (req_block_count == '0) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = fesr_pkg::ST_BAD_COUNT;
               end else if (req_start_block == '0) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = fesr_pkg::ST_BAD_START;
               end else begin
                  state_in = SCAN1;
               end
            end
         end

         // first pass: find touching extent, empty slot or marker
         SCAN1: begin
            shift_en = 1'b1;
            idx_in   = idx_ff - 1'b1;
            if (!found_ff) begin
               if (is_mark) begin
                  found_in = 1'b1;
                  if (have_empty_ff) begin
                     target_in = empty_ff;
                  end else begin
                     target_in = idx_ff;
                     if (idx_ff == '0) full_in = 1'b1;
                     else chk_below_in = 1'b1;
                  end
               end else if (head.len == '0) begin
                  have_empty_in = 1'b1;
                  empty_in      = idx_ff;
               end else if (touch_above) begin
                  size_in   = size_ff + fesr_pkg::SIZE_W'(head.len);
                  target_in = idx_ff;
                  found_in  = 1'b1;
               end else if (touch_below) begin
                  bloc_in   = head.start;
                  size_in   = size_ff + fesr_pkg::SIZE_W'(head.len);
                  target_in = idx_ff;
                  found_in  = 1'b1;
               end
            end else if (chk_below_ff) begin
               // marker slot is usable only if the slot below is a marker too
               chk_below_in = 1'b0;
               full_in      = !is_mark;
            end
            if (idx_ff == '0) begin
               idx_in = TOP_IDX;
               if (full_in) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = fesr_pkg::ST_FULL_DROP;
                  state_in      = IDLE;
               end else begin
                  state_in = SCAN2;
               end
            end
         end

         // second pass: join one more extent, fixing it as it passes
         SCAN2: begin
            shift_en = 1'b1;
            idx_in   = idx_ff - 1'b1;
            if (!done_ff) begin
               if (is_mark) begin
                  done_in = 1'b1;
               end else if (idx_ff != target_ff) begin
                  if (touch_above) begin
                     size_in  = size_ff + fesr_pkg::SIZE_W'(head.len);
                     wrap.len = '0;
                     done_in  = 1'b1;
                  end else if (touch_below) begin
                     wrap.len = fesr_pkg::LEN_W'(head.len + fesr_pkg::LEN_W'(size_ff));
                     size_in  = '0;
                     done_in  = 1'b1;
                  end
               end
            end
            if (idx_ff == '0) begin
               idx_in   = TOP_IDX;
               state_in = WRITE;
            end
         end

         // third pass: store the grown run in the target slot
         WRITE: begin
            shift_en = 1'b1;
            idx_in   = idx_ff - 1'b1;
            if (idx_ff == target_ff) begin
               wrap.start = bloc_ff;
               wrap.len   = fesr_pkg::LEN_W'(size_ff);
            end
            if (idx_ff == '0) begin
               idx_in        = TOP_IDX;
               rsp_strobe_in = 1'b1;
               rsp_status_in = fesr_pkg::ST_OK;
               state_in      = IDLE;
            end
         end

         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         idx_ff        <= TOP_IDX;
         found_ff      <= 1'b0;
         have_empty_ff <= 1'b0;
         chk_below_ff  <= 1'b0;
         full_ff       <= 1'b0;
         done_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         found_ff      <= found_in;
         have_empty_ff <= have_empty_in;
         chk_below_ff  <= chk_below_in;
         full_ff       <= full_in;
         done_ff       <= done_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      bloc_ff       <= bloc_in;
      size_ff       <= size_in;
      target_ff     <= target_in;
      empty_ff      <= empty_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy       = (state_ff != IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_status = rsp_status_ff;

endmodule
`default_nettype wire

// ===== rtl/free_extent_stack_release.sv =====
// ----------------------------------------------------------------------------
// free_extent_stack_release
// Releases a run of blocks into a coalescing stack of free extents.
// ----------------------------------------------------------------------------
// A release is taken when start is high and busy is low. A zero count or a
// zero start answers with an error status on the cycle after the transfer and
// keeps busy low. For a valid release the slots sit in a ring that rotates
// one slot a cycle past a single compare unit, once to find the merge target,
// once to join a neighbor, and once to store the run. A release dropped on a
// full stack ends after the first rotation. The status appears with rsp_strobe
// for one cycle, the first cycle with busy low again; the receiver must take
// it then.
// ----------------------------------------------------------------------------
`default_nettype none
module free_extent_stack_release #(
   parameter int STACK_DEPTH = 32
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic [fesr_pkg::IN_W-1:0]  req_start_block,
   input  wire logic [fesr_pkg::IN_W-1:0]  req_block_count,
   output logic                            rsp_strobe,
   output logic [1:0]                      rsp_status
);

   fesr_pkg::entry_type q   [STACK_DEPTH];
   fesr_pkg::entry_type wrap;
   logic                shift_en;

   fesr_ctrl #(.STACK_DEPTH(STACK_DEPTH)) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_start_block (req_start_block),
      .req_block_count (req_block_count),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .head            (q[STACK_DEPTH-1]),
      .wrap            (wrap),
      .shift_en        (shift_en)
   );

   // ring: top slot feeds the compare unit, its result re-enters at slot 0
   for (genvar k = 0; k < STACK_DEPTH; k++) begin : g_cell
      fesr_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift_en),
         .d_in     ((k == 0) ? wrap : q[(k == 0) ? 0 : k-1]),
         .q        (q[k])
      );
   end

endmodule
`default_nettype wire

// ===== rtl/fesr_checker.sv =====
// ----------------------------------------------------------------------------
// fesr_checker
// Port-level checks of the release handshake and status timing.
// ----------------------------------------------------------------------------
`default_nettype none
`include "free_extent_stack_release_defines.svh"
module fesr_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic [47:0] req_start_block,
   input wire logic [47:0] req_block_count,
   input wire logic        rsp_strobe,
   input wire logic [1:0]  rsp_status
);

   logic xfer;
   assign xfer = start && !busy;

   // zero count is reported on the next cycle
   `FESR_ASSERT_NEXT(a_bad_count, clock, reset, xfer && (req_block_count == '0), rsp_strobe && (rsp_status == fesr_pkg::ST_BAD_COUNT), "zero count not reported")

   // zero start with nonzero count is reported on the next cycle
   `FESR_ASSERT_NEXT(a_bad_start, clock, reset, xfer && (req_block_count != '0) && (req_start_block == '0), rsp_strobe && (rsp_status == fesr_pkg::ST_BAD_START), "zero start not reported")

   // a valid release occupies the block
   `FESR_ASSERT_NEXT(a_busy_on_valid, clock, reset, xfer && (req_block_count != '0) && (req_start_block != '0), busy && !rsp_strobe, "valid release did not start")

   // status is shown only while idle
   `FESR_ASSERT_NOW(a_strobe_idle, clock, reset, rsp_strobe, !busy, "status while busy")

endmodule

bind free_extent_stack_release fesr_checker u_fesr_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_start_block (req_start_block),
   .req_block_count (req_block_count),
   .rsp_strobe      (rsp_strobe),
   .rsp_status      (rsp_status)
);
`default_nettype wire
